>>> sv/icpd_pkg.sv
`default_nettype none

package icpd_pkg;

  localparam int unsigned NUM_IRQ = 5;
  localparam int unsigned IRQ_IDX_W = $clog2(NUM_IRQ);

  typedef enum logic [1:0] {
    MODE_READ    = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_SERVICE = 2'd2
  } mode_t;

  localparam logic [15:0] FLAG_ADDR       = 16'hFF0F;
  localparam logic [15:0] ENABLE_ADDR     = 16'hFFFF;
  localparam logic [7:0]  FLAG_READ_ONES  = 8'hE0;
  localparam logic [7:0]  OPEN_BUS        = 8'hFF;
  localparam logic [4:0]  DISPATCH_CYCLES = 5'(5 * 4);

  localparam logic [15:0] VECTOR_TABLE [NUM_IRQ] = '{
    16'h0040, 16'h0048, 16'h0050, 16'h0058, 16'h0060
  };

  typedef struct packed {
    mode_t       mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        master_enable;
    logic        cpu_halted;
    logic [15:0] current_pc;
    logic [4:0]  request_lines;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        dispatch;
    logic        wake;
    logic [15:0] next_pc;
    logic [15:0] pushed_pc;
    logic [4:0]  cycles_used;
  } result_t;

endpackage

`default_nettype wire

>>> sv/icpd_if.sv
`default_nettype none

interface icpd_item_if
  import icpd_pkg::*;
();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface icpd_result_if
  import icpd_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/icpd_in_reg.sv
`default_nettype none

module icpd_in_reg
  import icpd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  icpd_item_if.sink     up,
  icpd_item_if.source   down
);

  logic  valid_r;
  logic  valid_nxt;
  item_t data_r;
  logic  load;

  assign up.ready   = !valid_r || down.ready;
  assign load       = up.valid && up.ready;
  assign valid_nxt  = load || (valid_r && !down.ready);
  assign down.valid = valid_r;
  assign down.data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= up.data;
    end
  end

endmodule

`default_nettype wire

>>> sv/icpd_core.sv
`default_nettype none

module icpd_core
  import icpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  icpd_item_if.sink      req,
  icpd_result_if.source  res
);

  logic [7:0]           flag_r;
  logic [7:0]           flag_nxt;
  logic [7:0]           enable_r;
  logic [7:0]           enable_nxt;
  logic [7:0]           flag_or;
  logic [NUM_IRQ-1:0]   pending;
  logic [NUM_IRQ-1:0]   sel;
  logic [IRQ_IDX_W-1:0] sel_idx;
  logic                 commit;
  result_t              result;

  assign commit    = req.valid && res.ready;
  assign req.ready = res.ready;
  assign res.valid = req.valid;
  assign res.data  = result;

  assign flag_or = flag_r | {3'b000, req.data.request_lines};
  assign pending = flag_or[NUM_IRQ-1:0] & enable_r[NUM_IRQ-1:0];
  assign sel     = pending & (~pending + NUM_IRQ'(1));

  always_comb begin
    sel_idx = '0;
    for (int i = NUM_IRQ - 1; i >= 0; i--) begin
      if (sel[i]) begin
        sel_idx = IRQ_IDX_W'(i);
      end
    end
  end

  always_comb begin
    flag_nxt           = flag_or;
    enable_nxt         = enable_r;
    result.read_data   = 8'h00;
    result.dispatch    = 1'b0;
    result.wake        = 1'b0;
    result.next_pc     = req.data.current_pc;
    result.pushed_pc   = 16'h0000;
    result.cycles_used = 5'd0;
    case (req.data.mode)
      MODE_READ: begin
        if (req.data.address == FLAG_ADDR) begin
          result.read_data = flag_or | FLAG_READ_ONES;
        end else if (req.data.address == ENABLE_ADDR) begin
          result.read_data = enable_r;
        end else begin
          result.read_data = OPEN_BUS;
        end
      end
      MODE_WRITE: begin
        if (req.data.address == FLAG_ADDR) begin
          flag_nxt = req.data.write_data | {3'b000, req.data.request_lines};
        end else if (req.data.address == ENABLE_ADDR) begin
          enable_nxt = req.data.write_data;
        end
      end
      MODE_SERVICE: begin
        if (pending != '0) begin
          if (req.data.master_enable) begin
            flag_nxt           = flag_or & ~{3'b000, sel};
            result.dispatch    = 1'b1;
            result.wake        = 1'b1;
            result.next_pc     = VECTOR_TABLE[sel_idx];
            result.pushed_pc   = req.data.current_pc;
            result.cycles_used = DISPATCH_CYCLES;
          end else if (req.data.cpu_halted) begin
            result.wake = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= 8'h00;
      enable_r <= 8'h00;
    end else if (commit) begin
      flag_r   <= flag_nxt;
      enable_r <= enable_nxt;
    end
  end

  // The priority pick never selects more than one request.
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel))
    else $error("more than one interrupt selected");

  // A dispatch always releases the halted state too.
  a_dispatch_wakes: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid && result.dispatch |-> result.wake)
    else $error("dispatch without wake");

  // The serviced flag bit is cleared once the request is committed.
  a_serviced_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    commit && result.dispatch |=> (flag_r[NUM_IRQ-1:0] & $past(sel)) == '0)
    else $error("serviced flag bit still set");

  // Only a service check with something pending can dispatch.
  a_dispatch_source: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid && result.dispatch |->
      req.data.mode == MODE_SERVICE && pending != '0 && req.data.master_enable)
    else $error("dispatch without a pending enabled interrupt");

endmodule

`default_nettype wire

>>> sv/icpd_out_reg.sv
`default_nettype none

module icpd_out_reg
  import icpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  icpd_result_if.sink    up,
  icpd_result_if.source  down
);

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;
  logic    load;

  assign up.ready   = !valid_r || down.ready;
  assign load       = up.valid && up.ready;
  assign valid_nxt  = load || (valid_r && !down.ready);
  assign down.valid = valid_r;
  assign down.data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= up.data;
    end
  end

endmodule

`default_nettype wire

>>> sv/interrupt_controller_priority_dispatch_unit.sv
// Interrupt controller with a flag register (0xFF0F) and an enable register (0xFFFF).
// Requests arrive on in_chan: each one is a bus read, a bus write or a service
// check, and peripheral request lines are ORed into the flags with every request.
// Exactly one result per request leaves on out_chan, in request order.
// A request accepted into the input register has its result computed in the core
// and loaded into the output register, where the result waits until out_chan takes it.
// Flag and enable registers are updated when a request moves from the input register
// into the output register, so back-to-back requests see each other's effects.
// One request per cycle is sustained while out_chan does not stall; the work is a
// compare, a priority pick over five bits and a small vector table, all in the
// single stage between the registers. When out_chan stalls, the output register
// holds its result and the input register still takes one more request; in_chan
// ready drops only when both are full. Synchronous reset clears both registers'
// valid bits and sets the flag and enable registers to zero.
`default_nettype none

module interrupt_controller_priority_dispatch_unit
  import icpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  icpd_item_if.sink      in_chan,
  icpd_result_if.source  out_chan
);

  icpd_item_if   stage_req ();
  icpd_result_if stage_res ();

  icpd_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (in_chan),
    .down  (stage_req)
  );

  icpd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (stage_req),
    .res   (stage_res)
  );

  icpd_out_reg u_out_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (stage_res),
    .down  (out_chan)
  );

endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;
  import icpd_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned RANDOM_REQUESTS = 1550;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD_CYCLES = 120;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum int unsigned {
    SINK_STEADY,
    SINK_COIN,
    SINK_MOSTLY,
    SINK_PATTERN
  } sink_style_t;

  class irq_scoreboard;
    logic [7:0] flags;
    logic [7:0] enables;
    result_t awaited_responses[$];
    int unsigned failures;

    function new();
      flags = '0;
      enables = '0;
      failures = 0;
    endfunction

    // Applies one request to the modeled flag and enable registers and returns
    // the response the controller must give for it.
    function result_t dispatch_outcome(item_t it);
      result_t r;
      logic [4:0] pending;
      int unsigned lowest;
      r = '0;
      r.next_pc = it.current_pc;
      lowest = 0;
      flags = flags | {3'b000, it.request_lines};
      case (it.mode)
        MODE_READ: begin
          if (it.address == FLAG_ADDR) r.read_data = flags | FLAG_READ_ONES;
          else if (it.address == ENABLE_ADDR) r.read_data = enables;
          else r.read_data = OPEN_BUS;
        end
        MODE_WRITE: begin
          if (it.address == FLAG_ADDR) flags = it.write_data | {3'b000, it.request_lines};
          else if (it.address == ENABLE_ADDR) enables = it.write_data;
        end
        MODE_SERVICE: begin
          pending = flags[4:0] & enables[4:0];
          if (pending != '0) begin
            if (it.master_enable) begin
              for (int i = NUM_IRQ - 1; i >= 0; i--) begin
                if (pending[i]) lowest = i;
              end
              flags[lowest] = 1'b0;
              r.dispatch = 1'b1;
              r.wake = 1'b1;
              r.next_pc = VECTOR_TABLE[lowest];
              r.pushed_pc = it.current_pc;
              r.cycles_used = DISPATCH_CYCLES;
            end else if (it.cpu_halted) begin
              r.wake = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      return r;
    endfunction

    function void note_request(item_t it);
      awaited_responses.push_back(dispatch_outcome(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_responses.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("error: unexpected rd=%02h disp=%0d wake=%0d npc=%04h ppc=%04h cyc=%0d",
                   got.read_data, got.dispatch, got.wake, got.next_pc, got.pushed_pc,
                   got.cycles_used);
        return;
      end
      want = awaited_responses.pop_front();
      if (got.read_data !== want.read_data || got.dispatch !== want.dispatch ||
          got.wake !== want.wake || got.next_pc !== want.next_pc ||
          got.pushed_pc !== want.pushed_pc || got.cycles_used !== want.cycles_used) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("error: expected rd=%02h disp=%0d wake=%0d npc=%04h ppc=%04h cyc=%0d",
                   want.read_data, want.dispatch, want.wake, want.next_pc, want.pushed_pc,
                   want.cycles_used);
          $display("       actual   rd=%02h disp=%0d wake=%0d npc=%04h ppc=%04h cyc=%0d",
                   got.read_data, got.dispatch, got.wake, got.next_pc, got.pushed_pc,
                   got.cycles_used);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic hold_toggle;
  int unsigned cycle_count = 0;
  irq_scoreboard board;

  icpd_item_if req_chan ();
  icpd_result_if rsp_chan ();

  interrupt_controller_priority_dispatch_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(req_chan),
    .out_chan(rsp_chan)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic item_t make_request(mode_t m, logic [15:0] addr, logic [7:0] wdata,
                                         logic ime, logic halted, logic [15:0] pc,
                                         logic [4:0] lines);
    item_t it;
    it.mode = m;
    it.address = addr;
    it.write_data = wdata;
    it.master_enable = ime;
    it.cpu_halted = halted;
    it.current_pc = pc;
    it.request_lines = lines;
    return it;
  endfunction

  function automatic item_t random_request();
    item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.mode = pick < 25 ? MODE_READ : pick < 45 ? MODE_WRITE :
              pick < 92 ? MODE_SERVICE : mode_t'(MODE_SPARE);
    pick = $urandom_range(0, 9);
    it.address = pick < 4 ? FLAG_ADDR : pick < 8 ? ENABLE_ADDR : 16'($urandom);
    it.write_data = 8'($urandom);
    it.master_enable = $urandom_range(0, 3) != 0;
    it.cpu_halted = 1'($urandom_range(0, 1));
    it.current_pc = 16'($urandom);
    it.request_lines = $urandom_range(0, 2) == 0 ? 5'($urandom) : 5'd0;
    return it;
  endfunction

  // Valid stays high after acceptance until the next request or an idle period
  // replaces it.
  task automatic send_request(item_t it);
    req_chan.valid <= 1'b1;
    req_chan.data <= it;
    do @(posedge clk); while (!req_chan.ready);
    board.note_request(it);
  endtask

  task automatic idle_cycles(int unsigned n);
    req_chan.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    req_chan.valid <= 1'b0;
    do @(posedge clk); while (board.awaited_responses.size() != 0);
  endtask

  initial begin
    bit hold_seen;
    int unsigned hold_left;
    int unsigned style_left;
    sink_style_t style;
    rsp_chan.ready = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    style_left = 0;
    style = SINK_STEADY;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_chan.valid && rsp_chan.ready) board.check_result(rsp_chan.data);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (style_left == 0) begin
        style = sink_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 200);
      end else begin
        style_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_chan.ready <= 1'b0;
      end else begin
        case (style)
          SINK_STEADY: rsp_chan.ready <= 1'b1;
          SINK_COIN: rsp_chan.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: rsp_chan.ready <= $urandom_range(0, 9) != 0;
          default: rsp_chan.ready <= (cycle_count % 4) != 0;
        endcase
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned batch;
    int unsigned burst;
    board = new();
    rst_n = 1'b0;
    hold_toggle = 1'b0;
    req_chan.valid = 1'b0;
    req_chan.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, open bus and the enable register kept at full width.
    send_request(make_request(MODE_READ, FLAG_ADDR, 8'h00, 1'b0, 1'b0, 16'h0000, 5'h00));
    send_request(make_request(MODE_READ, ENABLE_ADDR, 8'h00, 1'b0, 1'b0, 16'h0000, 5'h00));
    send_request(make_request(MODE_READ, 16'h0000, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 5'h00));
    send_request(make_request(MODE_READ, 16'hFF0E, 8'h00, 1'b0, 1'b0, 16'hFFFF, 5'h00));
    send_request(make_request(MODE_SERVICE, 16'h0000, 8'h00, 1'b1, 1'b1, 16'h8000, 5'h00));
    send_request(make_request(MODE_WRITE, ENABLE_ADDR, 8'hFF, 1'b0, 1'b0, 16'h0000, 5'h00));
    send_request(make_request(MODE_READ, ENABLE_ADDR, 8'h00, 1'b0, 1'b0, 16'h0000, 5'h00));
    // Flag write together with requests, then every vector in priority order.
    send_request(make_request(MODE_WRITE, FLAG_ADDR, 8'hE0, 1'b0, 1'b0, 16'h0000, 5'h1F));
    send_request(make_request(MODE_READ, FLAG_ADDR, 8'h00, 1'b0, 1'b0, 16'h0000, 5'h00));
    send_request(make_request(MODE_SERVICE, 16'h0000, 8'h00, 1'b1, 1'b0, 16'hFFFF, 5'h00));
    send_request(make_request(MODE_SERVICE, 16'hFFFF, 8'h00, 1'b1, 1'b1, 16'h0000, 5'h00));
    send_request(make_request(MODE_SERVICE, 16'h5555, 8'h00, 1'b1, 1'b0, 16'h1234, 5'h00));
    send_request(make_request(MODE_SERVICE, 16'hAAAA, 8'h00, 1'b1, 1'b1, 16'hABCD, 5'h00));
    send_request(make_request(MODE_SERVICE, 16'h0000, 8'h00, 1'b1, 1'b0, 16'h7FFF, 5'h00));
    // Only the upper flag bits remain, and they never count as pending.
    send_request(make_request(MODE_SERVICE, 16'h0000, 8'h00, 1'b1, 1'b1, 16'h0100, 5'h00));
    send_request(make_request(mode_t'(MODE_SPARE), FLAG_ADDR, 8'hFF, 1'b1, 1'b1, 16'h0200,
                              5'h04));
    send_request(make_request(MODE_SERVICE, 16'h0000, 8'h00, 1'b0, 1'b0, 16'h0300, 5'h00));
    send_request(make_request(MODE_SERVICE, 16'h0000, 8'h00, 1'b0, 1'b1, 16'h0400, 5'h00));
    send_request(make_request(MODE_WRITE, 16'h1234, 8'hAA, 1'b0, 1'b0, 16'h0000, 5'h00));
    send_request(make_request(MODE_WRITE, FLAG_ADDR, 8'h00, 1'b0, 1'b0, 16'h0000, 5'h10));
    send_request(make_request(MODE_READ, FLAG_ADDR, 8'h00, 1'b0, 1'b0, 16'h0000, 5'h01));
    send_request(make_request(MODE_WRITE, ENABLE_ADDR, 8'h00, 1'b0, 1'b0, 16'h0000, 5'h00));
    send_request(make_request(MODE_SERVICE, 16'h0000, 8'h00, 1'b1, 1'b1, 16'h0500, 5'h00));
    send_request(make_request(MODE_READ, ENABLE_ADDR, 8'h00, 1'b0, 1'b0, 16'h0000, 5'h00));
    wait_for_drain();

    sent = 0;
    batch = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 40);
      if (batch == 8 || batch == 30) begin
        // The receiver holds off while a long burst keeps coming.
        hold_toggle <= ~hold_toggle;
        burst = 40;
      end
      repeat (burst) begin
        send_request(random_request());
        sent++;
      end
      if (batch == 20 || batch == 45) wait_for_drain();
      else if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
      batch++;
    end

    wait_for_drain();
    repeat (6) @(posedge clk);
    if (board.failures == 0 && board.awaited_responses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> interrupt_controller_priority_dispatch_unit.f
sv/icpd_pkg.sv
sv/icpd_if.sv
sv/icpd_in_reg.sv
sv/icpd_core.sv
sv/icpd_out_reg.sv
sv/interrupt_controller_priority_dispatch_unit.sv
bench/tb.sv
